FILE: rtl/stt_pkg.sv
package stt_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int TIME_W    = 48;
    localparam int TOK_W     = 32;
    localparam int RATE_W    = 16;
    localparam int SCALE     = 60000;

    // Entry layout: key, identity, opened, identified, ping, tokens, refill
    localparam int ENTRY_W = 64 + 64 + TIME_W * 4 + TOK_W;

    typedef enum logic [2:0] {
        KIND_OPEN     = 3'd0,
        KIND_IDENTIFY = 3'd1,
        KIND_HELLO    = 3'd2,
        KIND_CONSUME  = 3'd3,
        KIND_PONG     = 3'd4,
        KIND_PING     = 3'd5,
        KIND_CLOSE    = 3'd6,
        KIND_EXPIRE   = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_LIMIT        = 4'd1,
        ST_ALREADY_OPEN = 4'd2,
        ST_NOT_FOUND    = 4'd3,
        ST_NOT_IDENT    = 4'd4,
        ST_ALREADY_IDENT= 4'd5,
        ST_HELLO_REQ    = 4'd6,
        ST_ALREADY_WELC = 4'd7,
        ST_RATE_LIMITED = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        CAUSE_IDENTIFY = 2'd0,
        CAUSE_HELLO    = 2'd1,
        CAUSE_PONG     = 2'd2
    } cause_t;

    typedef enum logic [2:0] {
        REG_RATE     = 3'd0,
        REG_ID_TO    = 3'd1,
        REG_HELLO_TO = 3'd2,
        REG_PONG_TO  = 3'd3,
        REG_SLOTS    = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_REFILL,
        S_APPLY,
        S_EMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [63:0]       key;
        logic [63:0]       ident;
        logic [TIME_W-1:0] opened;
        logic [TIME_W-1:0] identified;
        logic [TIME_W-1:0] ping;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] refill;
    } entry_t;

endpackage

FILE: rtl/stt_ram.sv
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/session_table_token_bucket_unit.sv
// Session table with per-session token bucket.
// The key scan takes each slot through a read state and a compare state; a non-expire item
// stops at the matching slot or the end of the span, then passes S_REFILL (consume with a
// match only), S_APPLY and S_DONE. Expire scans the whole span, adding S_EMIT per expired
// session after the first, plus output stalls. One item at a time; the output register holds a
// waiting result so the next item can start. rst_n (async, active low) clears control, flags and
// output valid; the entry memory needs no clearing pass, since flags guard every read.
module session_table_token_bucket_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [175:0] s_tdata,   // session_key[63:0], identity_tag[127:64], now_ms[175:128]
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // status[3:0], expired_valid[4], expired_key[68:5],
                                    // expire_cause[70:69], zero fill [71]
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import stt_pkg::*;

    // Configuration registers
    logic [RATE_W-1:0] rate_reg;
    logic [31:0]       id_to_reg, hello_to_reg, pong_to_reg;
    logic [4:0]        slots_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RATE_W'(60);
            id_to_reg    <= 32'd30000;
            hello_to_reg <= 32'd30000;
            pong_to_reg  <= 32'd30000;
            slots_reg    <= 5'd16;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RATE:     rate_reg     <= pwdata[RATE_W-1:0];
                REG_ID_TO:    id_to_reg    <= pwdata;
                REG_HELLO_TO: hello_to_reg <= pwdata;
                REG_PONG_TO:  pong_to_reg  <= pwdata;
                REG_SLOTS:    slots_reg    <= pwdata[4:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_RATE:     prdata = {16'd0, rate_reg};
            REG_ID_TO:    prdata = id_to_reg;
            REG_HELLO_TO: prdata = hello_to_reg;
            REG_PONG_TO:  prdata = pong_to_reg;
            REG_SLOTS:    prdata = {27'd0, slots_reg};
            default:      prdata = '0;
        endcase
    end

    // Span of slots searched: saturate at the table size
    logic [CNT_W-1:0] span;
    assign span = (slots_reg > 5'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(slots_reg);

    // Per-slot flags live in flip-flops; reset clears them at once
    logic [MAX_SLOTS-1:0] used_reg, idf_reg, welc_reg, pingv_reg;
    logic [MAX_SLOTS-1:0] used_next, idf_next, welc_next, pingv_next;

    // Held input item
    kind_t             kind_reg;
    logic [63:0]       key_reg, ident_reg;
    logic [TIME_W-1:0] now_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;       // scan pointer
    logic [SLOT_W-1:0] hit_reg, hit_next;       // matched slot
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic              freev_reg, freev_next;
    logic              any_reg, any_next;       // an expired session waits in staging
    logic [TOK_W-1:0]  tok_reg, tok_next;       // refilled token count
    logic [TIME_W-1:0] elap_reg, elap_next;
    logic              late_reg, late_next;     // now > refill time
    logic [3:0]        stat_reg, stat_next;     // status of a non-expire item
    logic [63:0]       stg_key_reg, stg_key_next;     // staged expired key
    logic [1:0]        stg_cause_reg, stg_cause_next; // staged expire cause

    // Output register
    logic              ov_reg, ov_next;
    logic [3:0]        ost_reg, ost_next;
    logic              oexp_reg, oexp_next;
    logic [63:0]       okey_reg, okey_next;
    logic [1:0]        ocause_reg, ocause_next;
    logic              olast_reg, olast_next;

    // Entry memory
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    entry_t            mem_wdata, rd;
    logic [ENTRY_W-1:0] rd_bits;

    stt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_bits)
    );
    assign rd = entry_t'(rd_bits);

    // The output register parts the sides: a waiting result does not hold off input
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, ocause_reg, okey_reg, oexp_reg, ost_reg};
    assign m_tlast  = olast_reg;

    // Slot under evaluation: the entry read in the previous cycle
    logic [SLOT_W-1:0] cur;
    logic              cur_in;
    assign cur    = idx_reg[SLOT_W-1:0];
    assign cur_in = idx_reg < span;

    // Deadline check for the current slot
    logic [TIME_W-1:0] dl_start;
    logic [31:0]       dl_to;
    logic              dl_hit;
    logic [TIME_W:0]   dl_diff;
    logic [1:0]        dl_cause;
    always_comb
    begin
        dl_start = rd.opened;
        dl_to    = id_to_reg;
        dl_cause = CAUSE_IDENTIFY;
        if (idf_reg[cur] && !welc_reg[cur])
        begin
            dl_start = rd.identified;
            dl_to    = hello_to_reg;
            dl_cause = CAUSE_HELLO;
        end
        else if (idf_reg[cur])
        begin
            dl_start = rd.ping;
            dl_to    = pong_to_reg;
            dl_cause = CAUSE_PONG;
        end
        dl_diff = {1'b0, now_reg} - {1'b0, dl_start};
        dl_hit  = used_reg[cur] && !dl_diff[TIME_W] && (dl_diff[TIME_W-1:0] >= TIME_W'(dl_to))
                  && (!welc_reg[cur] || pingv_reg[cur]);
    end

    // Refill arithmetic, split over S_EVAL (elapsed time) and S_REFILL (product, sum and cap)
    logic [TIME_W:0]   rf_diff;
    logic [TOK_W-1:0]  cap;
    logic [47:0]       cap_full;
    logic [TOK_W+1:0]  rf_sum;
    logic [TOK_W+15:0] rf_prod;
    assign rf_diff  = {1'b0, now_reg} - {1'b0, rd.refill};
    assign cap_full = 48'(rate_reg) * 48'(SCALE);
    assign cap      = cap_full[TOK_W-1:0];
    assign rf_prod  = (TOK_W+16)'(elap_reg[15:0]) * (TOK_W+16)'(rate_reg);
    assign rf_sum   = (TOK_W+2)'(rf_prod[TOK_W:0]) + (TOK_W+2)'(tok_reg);

    entry_t upd;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid && s_tready) state_next = S_SCAN;
            S_SCAN:   state_next = S_EVAL;
            S_EVAL:
            begin
                if (kind_reg == KIND_EXPIRE)
                begin
                    if (!cur_in)
                        state_next = S_DONE;
                    else if (dl_hit && any_reg)
                        state_next = S_EMIT;
                    else
                        state_next = S_SCAN;
                end
                else if (!cur_in || (used_reg[cur] && rd.key == key_reg))
                    state_next = (kind_reg == KIND_CONSUME && cur_in) ? S_REFILL : S_APPLY;
                else
                    state_next = S_SCAN;
            end
            S_REFILL: state_next = S_APPLY;
            S_APPLY:  state_next = S_DONE;
            S_EMIT:   if (!ov_reg || m_tready) state_next = S_SCAN;
            S_DONE:   if (!ov_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        freev_next     = freev_reg;
        any_next       = any_reg;
        tok_next       = tok_reg;
        elap_next      = elap_reg;
        late_next      = late_reg;
        stat_next      = stat_reg;
        stg_key_next   = stg_key_reg;
        stg_cause_next = stg_cause_reg;
        used_next      = used_reg;
        idf_next       = idf_reg;
        welc_next      = welc_reg;
        pingv_next     = pingv_reg;
        ov_next        = ov_reg && !m_tready;
        ost_next       = ost_reg;
        oexp_next      = oexp_reg;
        okey_next      = okey_reg;
        ocause_next    = ocause_reg;
        olast_next     = olast_reg;
        mem_we         = 1'b0;
        mem_waddr      = hit_reg;
        mem_raddr      = cur;
        upd            = rd;
        mem_wdata      = rd;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                freev_next = 1'b0;
                any_next   = 1'b0;
            end
            S_SCAN: mem_raddr = cur;
            S_EVAL:
            begin
                if (kind_reg == KIND_EXPIRE)
                begin
                    // First expired session goes straight to staging; later ones wait in
                    // S_EMIT until the staged one can move to the output
                    if (cur_in && dl_hit && !any_reg)
                    begin
                        stg_key_next    = rd.key;
                        stg_cause_next  = dl_cause;
                        used_next[cur]  = 1'b0;
                        idf_next[cur]   = 1'b0;
                        welc_next[cur]  = 1'b0;
                        pingv_next[cur] = 1'b0;
                        any_next        = 1'b1;
                        idx_next        = idx_reg + 1'b1;
                    end
                    else if (cur_in && !dl_hit)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (cur_in && !used_reg[cur] && !freev_reg)
                    begin
                        freev_next = 1'b1;
                        free_next  = cur;
                    end
                    if (cur_in && used_reg[cur] && rd.key == key_reg)
                    begin
                        found_next = 1'b1;
                        hit_next   = cur;
                        late_next  = !rf_diff[TIME_W] && (rf_diff[TIME_W-1:0] != '0);
                        elap_next  = rf_diff[TIME_W-1:0];
                        tok_next   = rd.tokens;
                    end
                    else if (cur_in)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    mem_raddr = cur;
                end
            end
            S_REFILL:
            begin
                mem_raddr = hit_reg;
                if (late_reg)
                begin
                    if (elap_reg >= TIME_W'(SCALE) || rf_sum >= (TOK_W+2)'(cap))
                        tok_next = cap;
                    else
                        tok_next = rf_sum[TOK_W-1:0];
                end
            end
            S_APPLY:
            begin
                mem_raddr = hit_reg;
                stat_next = ST_OK;
                if (kind_reg == KIND_OPEN)
                begin
                    if (found_reg)
                        stat_next = ST_ALREADY_OPEN;
                    else if (!freev_reg)
                        stat_next = ST_LIMIT;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = free_reg;
                        upd.key    = key_reg;
                        upd.opened = now_reg;
                        upd.tokens = cap;
                        upd.refill = now_reg;
                        mem_wdata  = upd;
                        used_next[free_reg]  = 1'b1;
                        idf_next[free_reg]   = 1'b0;
                        welc_next[free_reg]  = 1'b0;
                        pingv_next[free_reg] = 1'b0;
                    end
                end
                else if (!found_reg)
                    stat_next = ST_NOT_FOUND;
                else
                begin
                    case (kind_reg)
                        KIND_IDENTIFY:
                        begin
                            if (idf_reg[hit_reg])
                                stat_next = (rd.ident == ident_reg) ? ST_OK : ST_ALREADY_IDENT;
                            else
                            begin
                                idf_next[hit_reg] = 1'b1;
                                upd.ident      = ident_reg;
                                upd.identified = now_reg;
                                mem_we    = 1'b1;
                                mem_wdata = upd;
                            end
                        end
                        KIND_HELLO:
                        begin
                            if (!idf_reg[hit_reg])
                                stat_next = ST_NOT_IDENT;
                            else if (welc_reg[hit_reg])
                                stat_next = ST_ALREADY_WELC;
                            else
                                welc_next[hit_reg] = 1'b1;
                        end
                        KIND_CONSUME:
                        begin
                            if (rate_reg == '0)
                                stat_next = ST_RATE_LIMITED;
                            else
                            begin
                                if (late_reg)
                                    upd.refill = now_reg;
                                if (tok_reg < TOK_W'(SCALE))
                                begin
                                    stat_next  = ST_RATE_LIMITED;
                                    upd.tokens = tok_reg;
                                end
                                else
                                    upd.tokens = tok_reg - TOK_W'(SCALE);
                                mem_we    = 1'b1;
                                mem_wdata = upd;
                            end
                        end
                        KIND_PONG: pingv_next[hit_reg] = 1'b0;
                        KIND_PING:
                        begin
                            if (!welc_reg[hit_reg])
                                stat_next = ST_HELLO_REQ;
                            else if (!pingv_reg[hit_reg])
                            begin
                                pingv_next[hit_reg] = 1'b1;
                                upd.ping  = (now_reg == '0) ? TIME_W'(1) : now_reg;
                                mem_we    = 1'b1;
                                mem_wdata = upd;
                            end
                        end
                        default:
                        begin
                            used_next[hit_reg]  = 1'b0;
                            idf_next[hit_reg]   = 1'b0;
                            welc_next[hit_reg]  = 1'b0;
                            pingv_next[hit_reg] = 1'b0;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                // Hold the read of this slot; once the output frees, move the staged
                // session out (not last) and stage this one
                mem_raddr = cur;
                if (!ov_reg || m_tready)
                begin
                    ov_next         = 1'b1;
                    ost_next        = ST_OK;
                    oexp_next       = 1'b1;
                    okey_next       = stg_key_reg;
                    ocause_next     = stg_cause_reg;
                    olast_next      = 1'b0;
                    stg_key_next    = rd.key;
                    stg_cause_next  = dl_cause;
                    used_next[cur]  = 1'b0;
                    idf_next[cur]   = 1'b0;
                    welc_next[cur]  = 1'b0;
                    pingv_next[cur] = 1'b0;
                    idx_next        = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next     = 1'b1;
                    ost_next    = stat_reg;
                    oexp_next   = 1'b0;
                    okey_next   = '0;
                    ocause_next = CAUSE_IDENTIFY;
                    olast_next  = 1'b1;
                    if (kind_reg == KIND_EXPIRE)
                    begin
                        ost_next = ST_OK;
                        if (any_reg)
                        begin
                            oexp_next   = 1'b1;
                            okey_next   = stg_key_reg;
                            ocause_next = stg_cause_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            idf_reg   <= '0;
            welc_reg  <= '0;
            pingv_reg <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            freev_reg <= 1'b0;
            any_reg   <= 1'b0;
            late_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            idf_reg   <= idf_next;
            welc_reg  <= welc_next;
            pingv_reg <= pingv_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            freev_reg <= freev_next;
            any_reg   <= any_next;
            late_reg  <= late_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg  <= kind_t'(s_tuser);
            key_reg   <= s_tdata[63:0];
            ident_reg <= s_tdata[127:64];
            now_reg   <= s_tdata[175:128];
        end
        hit_reg       <= hit_next;
        free_reg      <= free_next;
        tok_reg       <= tok_next;
        elap_reg      <= elap_next;
        stat_reg      <= stat_next;
        stg_key_reg   <= stg_key_next;
        stg_cause_reg <= stg_cause_next;
        ost_reg       <= ost_next;
        oexp_reg      <= oexp_next;
        okey_reg      <= okey_next;
        ocause_reg    <= ocause_next;
        olast_reg     <= olast_next;
    end

endmodule

FILE: rtl/stt_checker.sv
module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One item at a time: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Non-expiry results are always final
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> m_tlast)
        else $error("plain result without last");

    // Expiry results carry status ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0)
        else $error("expired result with nonzero status");

    // Status stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'd8)
        else $error("status code out of range");

endmodule

bind session_table_token_bucket_unit stt_checker u_stt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
